[sv/box_filter_image_downscale_defines.svh]
// Assertion macros for the box filter downscaler.
// Included by modules that carry concurrent assertions; expects clk and rst in scope.
`ifndef BOX_FILTER_IMAGE_DOWNSCALE_DEFINES_SVH
`define BOX_FILTER_IMAGE_DOWNSCALE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define BFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("box filter assertion failed");
// checked at every edge, reset included
`define BFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("box filter assertion failed");
`else
`define BFD_ASSERT(label, prop)
`define BFD_ASSERT_ALWAYS(label, prop)
`endif
`endif

[sv/bfd_pkg.sv]
// Shared constants, types and command/status structs of the box filter downscaler.
// No dependencies.
`default_nettype none
package bfd_pkg;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W   = 13;                 // size registers
  localparam int POS_W   = $clog2(MAX_WIDTH);  // column position / band
  localparam int ROW_W   = 12;                 // row position / band
  localparam int ACC_W   = 25;                 // band boundary products
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 25;
  localparam int RAM_W   = 3 * SUM_W + CNT_W;
  localparam int DIVX_W  = SUM_W + 1;
  localparam int QBIT_W  = 3;                  // quotient bit index, 8 bits of mean
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              acc;
    logic              div_step;
    logic [QBIT_W-1:0] div_bit;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic box_end;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

[sv/bfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[sv/bfd_ctrl.sv]
// Sequencer of the box filter downscaler: accept, accumulate, divide, hand off.
// Depends on bfd_pkg and box_filter_image_downscale_defines.svh.
`default_nettype none
`include "box_filter_image_downscale_defines.svh"
module bfd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bfd_pkg::status_t status,
  output bfd_pkg::cmd_t        cmd
);
  bfd_pkg::state_t state, state_next;
  logic [bfd_pkg::QBIT_W-1:0] div_bit, div_bit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bfd_pkg::S_IDLE;
      div_bit <= '0;
    end else begin
      state   <= state_next;
      div_bit <= div_bit_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_bit_next = div_bit;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.div_bit  = div_bit;
    unique case (state)
      bfd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = bfd_pkg::S_ACC;
        end
      end
      bfd_pkg::S_ACC: begin
        cmd.acc = 1'b1;
        if (status.box_end) begin
          div_bit_next = '1;
          state_next   = bfd_pkg::S_DIV;
        end else begin
          state_next = bfd_pkg::S_IDLE;
        end
      end
      bfd_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_bit_next = div_bit - 1'b1;
        if (div_bit == '0) begin
          state_next = bfd_pkg::S_DONE;
        end
      end
      bfd_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = bfd_pkg::S_IDLE;
        end
      end
      default: state_next = bfd_pkg::S_IDLE;
    endcase
  end

  `BFD_ASSERT(a_acc_follows_accept, cmd.accept |=> state == bfd_pkg::S_ACC)
  `BFD_ASSERT(a_div_ends, (state == bfd_pkg::S_DIV && div_bit == '0) |=> state == bfd_pkg::S_DONE)
  `BFD_ASSERT(a_no_overwrite, cmd.load_out |-> !status.out_busy)
  `BFD_ASSERT_ALWAYS(a_reset_idle, rst |=> state == bfd_pkg::S_IDLE)
endmodule
`default_nettype wire

[sv/bfd_datapath.sv]
// Datapath of the box filter downscaler: size registers, band tracking,
// column sum RAM, 8-step restoring divider and output register.
// Depends on bfd_pkg and bfd_ram.
`default_nettype none
module bfd_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [bfd_pkg::PIX_W-1:0]        red_in,
  input  wire logic [bfd_pkg::PIX_W-1:0]        green_in,
  input  wire logic [bfd_pkg::PIX_W-1:0]        blue_in,
  input  wire bfd_pkg::cmd_t                    cmd,
  output bfd_pkg::status_t                      status,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [bfd_pkg::PIX_W-1:0]             red_avg,
  output logic [bfd_pkg::PIX_W-1:0]             green_avg,
  output logic [bfd_pkg::PIX_W-1:0]             blue_avg,
  output logic [bfd_pkg::POS_W-1:0]             out_col,
  output logic [bfd_pkg::ROW_W-1:0]             out_row,
  output logic                                  frame_last
);
  localparam int DW = bfd_pkg::DIM_W;
  localparam int AW = bfd_pkg::ACC_W;
  localparam int SW = bfd_pkg::SUM_W;
  localparam int CW = bfd_pkg::CNT_W;
  localparam int PW = bfd_pkg::PIX_W;

  // size registers
  logic [DW-1:0] src_width, src_height, out_width, out_height;
  logic [DW-1:0] sw, sh, ow, oh;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DW'(640);
      src_height <= DW'(480);
      out_width  <= DW'(640);
      out_height <= DW'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfd_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[DW-1:0];
        bfd_pkg::REG_SRC_HEIGHT: src_height <= cfg_data[DW-1:0];
        bfd_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data[DW-1:0];
        bfd_pkg::REG_OUT_HEIGHT: out_height <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = (src_width == '0) ? DW'(1) :
         (src_width > DW'(bfd_pkg::MAX_WIDTH)) ? DW'(bfd_pkg::MAX_WIDTH) : src_width;
    sh = (src_height == '0) ? DW'(1) :
         (src_height > DW'(bfd_pkg::MAX_HEIGHT)) ? DW'(bfd_pkg::MAX_HEIGHT) : src_height;
    ow = (out_width == '0) ? DW'(1) : (out_width > sw) ? sw : out_width;
    oh = (out_height == '0) ? DW'(1) : (out_height > sh) ? sh : out_height;
  end

  // position and bands; col_acc = (band+1)*sw, col_lim = (x+1)*ow, same for rows
  logic [bfd_pkg::POS_W-1:0] src_col, col_band, k_new;
  logic [bfd_pkg::ROW_W-1:0] src_row, row_band, j_cur;
  logic [AW-1:0] col_acc, col_lim, row_acc, row_lim;
  logic          row_first;
  logic          col_zero, row_zero, col_adv, col_end, row_end, col_start, row_start;
  logic [AW-1:0] ca_eff, ca_new, cb_now, cb_next, ra, rb, rb_next;
  logic          last_col, last_row;

  always_comb begin
    col_zero  = (src_col == '0);
    row_zero  = (src_row == '0);
    ca_eff    = col_zero ? AW'(sw) : col_acc;
    cb_now    = col_zero ? AW'(ow) : col_lim;
    col_adv   = !col_zero && (ca_eff < cb_now);
    k_new     = col_zero ? '0 : col_band + bfd_pkg::POS_W'(col_adv);
    ca_new    = ca_eff + (col_adv ? AW'(sw) : '0);
    cb_next   = cb_now + AW'(ow);
    col_end   = ca_new < cb_next;
    col_start = col_zero || col_adv;
    j_cur     = row_zero ? '0 : row_band;
    ra        = row_zero ? AW'(sh) : row_acc;
    rb        = row_zero ? AW'(oh) : row_lim;
    rb_next   = rb + AW'(oh);
    row_end   = ra < rb_next;
    row_start = row_zero || row_first;
    last_col  = ({1'b0, src_col} == sw - 1'b1);
    last_row  = ({1'b0, src_row} == sh - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      src_col  <= '0;
      src_row  <= '0;
      col_band <= '0;
      row_band <= '0;
    end else if (cmd.accept) begin
      col_band <= k_new;
      col_acc  <= ca_new;
      col_lim  <= cb_next;
      if (last_col) begin
        src_col <= '0;
        if (last_row) begin
          src_row <= '0;
        end else begin
          src_row   <= src_row + 1'b1;
          row_lim   <= rb_next;
          row_band  <= j_cur + bfd_pkg::ROW_W'(row_end);
          row_acc   <= ra + (row_end ? AW'(sh) : '0);
          row_first <= row_end;
        end
      end else begin
        src_col <= src_col + 1'b1;
      end
    end
  end

  // pixel and box info captured at accept
  logic [PW-1:0] pix_r, pix_g, pix_b;
  logic          box_start, box_end;
  logic [bfd_pkg::POS_W-1:0] box_col;
  logic [bfd_pkg::ROW_W-1:0] box_row;
  logic          box_last;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r     <= red_in;
      pix_g     <= green_in;
      pix_b     <= blue_in;
      box_start <= col_start && row_start;
      box_end   <= col_end && row_end;
      box_col   <= k_new;
      box_row   <= bfd_pkg::ROW_W'(oh - 1'b1 - DW'(j_cur));
      box_last  <= ({1'b0, k_new} == ow - 1'b1) && ({1'b0, j_cur} == oh - 1'b1);
    end
  end

  assign status.box_end = box_end;

  // column sums: {count, blue, green, red}
  logic [bfd_pkg::RAM_W-1:0] rd, wd;
  logic [SW-1:0] new_r, new_g, new_b;
  logic [CW-1:0] new_cnt;

  always_comb begin
    if (box_start) begin
      new_r   = SW'(pix_r);
      new_g   = SW'(pix_g);
      new_b   = SW'(pix_b);
      new_cnt = CW'(1);
    end else begin
      new_r   = rd[SW-1:0] + SW'(pix_r);
      new_g   = rd[2*SW-1:SW] + SW'(pix_g);
      new_b   = rd[3*SW-1:2*SW] + SW'(pix_b);
      new_cnt = rd[bfd_pkg::RAM_W-1:3*SW] + 1'b1;
    end
    wd = {new_cnt, new_b, new_g, new_r};
  end

  bfd_ram #(
    .WIDTH (bfd_pkg::RAM_W),
    .DEPTH (bfd_pkg::MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (col_band),
    .wdata (wd),
    .re    (cmd.accept),
    .raddr (k_new),
    .rdata (rd)
  );

  // restoring divider, one quotient bit per step, three channels side by side
  logic [SW-1:0] rem_r, rem_g, rem_b;
  logic [CW-1:0] div_cnt;
  logic [PW-1:0] q_r, q_g, q_b;
  logic [bfd_pkg::DIVX_W-1:0] dsh;
  logic [bfd_pkg::DIVX_W-1:0] ex_r, ex_g, ex_b;

  always_comb begin
    dsh  = bfd_pkg::DIVX_W'(div_cnt) << cmd.div_bit;
    ex_r = {1'b0, rem_r};
    ex_g = {1'b0, rem_g};
    ex_b = {1'b0, rem_b};
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      rem_r   <= new_r;
      rem_g   <= new_g;
      rem_b   <= new_b;
      div_cnt <= new_cnt;
      q_r     <= '0;
      q_g     <= '0;
      q_b     <= '0;
    end else if (cmd.div_step) begin
      if (ex_r >= dsh) begin
        rem_r <= SW'(ex_r - dsh);
        q_r[cmd.div_bit] <= 1'b1;
      end
      if (ex_g >= dsh) begin
        rem_g <= SW'(ex_g - dsh);
        q_g[cmd.div_bit] <= 1'b1;
      end
      if (ex_b >= dsh) begin
        rem_b <= SW'(ex_b - dsh);
        q_b[cmd.div_bit] <= 1'b1;
      end
    end
  end

  // output register
  logic cnt_zero;
  assign cnt_zero        = (div_cnt == '0);
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_avg    <= cnt_zero ? '0 : q_r;
      green_avg  <= cnt_zero ? '0 : q_g;
      blue_avg   <= cnt_zero ? '0 : q_b;
      out_col    <= box_col;
      out_row    <= box_row;
      frame_last <= box_last;
    end
  end
endmodule
`default_nettype wire

[sv/box_filter_image_downscale.sv]
// Box filter downscaler, top level. A pixel without a finished box passes through
// accept, then RAM read-modify-write; a pixel that closes a box also passes the
// 8-step divider and a hand-off state, which waits while the output register is full.
// The output register lets the next pixel be taken while a result waits.
// Reset (rst, synchronous) loads sizes 640x480 -> 640x480 and restarts the frame;
// the column sum RAM needs no clearing pass. Uses bfd_pkg, bfd_ctrl, bfd_datapath.
`default_nettype none
module box_filter_image_downscale (
  input  wire logic        clk,
  input  wire logic        rst,
  // source pixels
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  // averaged pixels
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // red_avg, green_avg, blue_avg, out_col, out_row
  output logic             m_axis_tlast,   // frame_last
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  bfd_pkg::cmd_t    cmd;
  bfd_pkg::status_t status;
  logic [bfd_pkg::PIX_W-1:0] red_avg, green_avg, blue_avg;
  logic [bfd_pkg::POS_W-1:0] out_col;
  logic [bfd_pkg::ROW_W-1:0] out_row;

  // writes are taken at once; any transaction restarts the frame
  assign cfg_ready = 1'b1;

  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bfd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red_in     (s_axis_tdata[7:0]),
    .green_in   (s_axis_tdata[15:8]),
    .blue_in    (s_axis_tdata[23:16]),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .red_avg    (red_avg),
    .green_avg  (green_avg),
    .blue_avg   (blue_avg),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (m_axis_tlast)
  );

  assign m_axis_tdata = {out_row, out_col, blue_avg, green_avg, red_avg};
endmodule
`default_nettype wire

[test/box_filter_image_downscale_checker.sv]
// Checker for the box filter downscaler: watches the pixel, result and register
// write channels, predicts each averaged pixel and compares it field by field.
// Depends on bfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module box_filter_image_downscale_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               results_seen,
  output int               frames_seen
);
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } avg_pixel_t;

  avg_pixel_t avg_queue[$];

  logic [bfd_pkg::DIM_W-1:0] src_w, src_h, out_w, out_h;
  logic [bfd_pkg::SUM_W-1:0] col_red[bfd_pkg::MAX_WIDTH];
  logic [bfd_pkg::SUM_W-1:0] col_green[bfd_pkg::MAX_WIDTH];
  logic [bfd_pkg::SUM_W-1:0] col_blue[bfd_pkg::MAX_WIDTH];
  logic [bfd_pkg::CNT_W-1:0] col_cnt[bfd_pkg::MAX_WIDTH];
  int unsigned pos_x, pos_y, band_x, band_y;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // first source index of band k, n source units over m bands
  function automatic int unsigned band_lo(int unsigned k, int unsigned n, int unsigned m);
    longint unsigned p;
    p = longint'(k) * longint'(n);
    return int'(p / m);
  endfunction

  task automatic take_pixel(input logic [23:0] px);
    int unsigned sw, sh, ow, oh, c_lo, c_hi, r_lo, r_hi, idx;
    avg_pixel_t e;
    sw = clamp_dim(src_w, bfd_pkg::MAX_WIDTH);
    sh = clamp_dim(src_h, bfd_pkg::MAX_HEIGHT);
    ow = clamp_dim(out_w, sw);
    oh = clamp_dim(out_h, sh);
    if (pos_x >= sw || pos_y >= sh) begin
      pos_x = 0; pos_y = 0; band_x = 0; band_y = 0;
    end
    if (pos_x == 0) begin
      band_x = 0;
      if (pos_y == 0) band_y = 0;
      else if (band_y + 1 < oh && pos_y >= band_lo(band_y + 1, sh, oh)) band_y++;
    end else if (band_x + 1 < ow && pos_x >= band_lo(band_x + 1, sw, ow)) begin
      band_x++;
    end
    if (band_x >= ow) band_x = ow - 1;
    if (band_y >= oh) band_y = oh - 1;
    c_lo = band_lo(band_x, sw, ow);
    c_hi = band_lo(band_x + 1, sw, ow);
    r_lo = band_lo(band_y, sh, oh);
    r_hi = band_lo(band_y + 1, sh, oh);
    idx  = band_x % bfd_pkg::MAX_WIDTH;
    // first pixel of a box overwrites the column entry
    if (pos_y == r_lo && pos_x == c_lo) begin
      col_red[idx] = px[7:0]; col_green[idx] = px[15:8]; col_blue[idx] = px[23:16];
      col_cnt[idx] = 1;
    end else begin
      col_red[idx]   += px[7:0];
      col_green[idx] += px[15:8];
      col_blue[idx]  += px[23:16];
      col_cnt[idx]   += 1;
    end
    if (pos_y + 1 >= r_hi && pos_x + 1 >= c_hi) begin
      e.red   = (col_cnt[idx] == 0) ? 8'd0 : 8'(col_red[idx] / col_cnt[idx]);
      e.green = (col_cnt[idx] == 0) ? 8'd0 : 8'(col_green[idx] / col_cnt[idx]);
      e.blue  = (col_cnt[idx] == 0) ? 8'd0 : 8'(col_blue[idx] / col_cnt[idx]);
      e.col   = 12'(band_x);
      e.row   = 12'(oh - 1 - band_y);   // source is bottom-up
      e.last  = (band_x + 1 == ow) && (band_y + 1 == oh);
      avg_queue = {avg_queue, e};
    end
    pos_x++;
    if (pos_x >= sw) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= sh) pos_y = 0;
    end
  endtask

  task automatic check_result(input avg_pixel_t got);
    avg_pixel_t want;
    if (avg_queue.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected averaged pixel %h", got);
    end else begin
      want = avg_queue.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp r%0d g%0d b%0d col%0d row%0d last%0d,",
                    " got r%0d g%0d b%0d col%0d row%0d last%0d"},
                   want.red, want.green, want.blue, want.col, want.row, want.last,
                   got.red, got.green, got.blue, got.col, got.row, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      src_w = 640; src_h = 480; out_w = 640; out_h = 480;
      pos_x = 0; pos_y = 0; band_x = 0; band_y = 0;
      avg_queue.delete();
      errors = 0; results_seen = 0; frames_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bfd_pkg::REG_SRC_WIDTH:  src_w = cfg_data[bfd_pkg::DIM_W-1:0];
          bfd_pkg::REG_SRC_HEIGHT: src_h = cfg_data[bfd_pkg::DIM_W-1:0];
          bfd_pkg::REG_OUT_WIDTH:  out_w = cfg_data[bfd_pkg::DIM_W-1:0];
          bfd_pkg::REG_OUT_HEIGHT: out_h = cfg_data[bfd_pkg::DIM_W-1:0];
          default: ;
        endcase
        // any write restarts the frame
        pos_x = 0; pos_y = 0; band_x = 0; band_y = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tlast) frames_seen++;
        check_result({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                      m_axis_tdata[35:24], m_axis_tdata[47:36], m_axis_tlast});
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
    end
    pending = avg_queue.size();
  end
endmodule
`default_nettype wire

[test/tb_box_filter_image_downscale.sv]
// Testbench top for the box filter downscaler: clock, reset, pixel and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on bfd_pkg, box_filter_image_downscale, box_filter_image_downscale_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_box_filter_image_downscale;
  localparam int IDLE_LIMIT  = 3000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 16;    // settle time for pixels without a result
  localparam int LONG_HOLD   = 400;   // receiver stall that backs up the block
  localparam int RANDOM_PIX  = 750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;      // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // red, green, blue, out_col[35:24], out_row[47:36]
  logic        m_axis_tlast;           // frame_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending, results_seen, frames_seen;
  int pixels_sent, reg_writes, idle_cycles;
  bit no_gaps;        // phase without idling on either side
  bit hold_request;   // asks the receiver for one long stall

  always #1 clk = ~clk;

  box_filter_image_downscale dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  box_filter_image_downscale_checker u_check (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .results_seen, .frames_seen
  );

  // watchdog: counts cycles without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result receiver: random stalls per transaction, one long stall on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready = 1'b0;
        hold_request = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          m_axis_tready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // one pixel transaction; entered and left at a falling edge
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {b, g, r};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // wait for every expected result, then let pixels without a result settle
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bfd_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_index = idx;
    cfg_data  = bfd_pkg::CFG_DATA_W'(val);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned ow, input int unsigned oh);
    wait_drained();
    write_reg(bfd_pkg::REG_SRC_WIDTH, sw);
    write_reg(bfd_pkg::REG_SRC_HEIGHT, sh);
    write_reg(bfd_pkg::REG_OUT_WIDTH, ow);
    write_reg(bfd_pkg::REG_OUT_HEIGHT, oh);
  endtask

  initial begin
    int unsigned sw, sh, ow, oh, count, phase;
    logic [bfd_pkg::CFG_IDX_W-1:0] order[4];
    pixels_sent = 0;
    reg_writes  = 0;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset sizes map 1:1, so every pixel closes a box
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'haa);
    send_pixel(8'h55, 8'hff, 8'h00);
    // 1:1 frame while the receiver stalls long: results pile up, input stalls
    set_sizes(4, 4, 4, 4);
    hold_request = 1'b1;
    repeat (20) send_random_pixel();
    // 3x2 down to 2x1: uneven column bands, two rows per band, frame wrap
    set_sizes(3, 2, 2, 1);
    repeat (7) send_random_pixel();
    // zero sizes clamp to 1x1: every pixel is a whole frame
    set_sizes(0, 0, 0, 0);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    // oversized: source clamps to 4096, output larger than source clamps too
    set_sizes(8191, 8191, 5000, 8191);
    repeat (3) send_random_pixel();
    // 4096-wide row into a single column band, partly fed
    set_sizes(4096, 1, 1, 1);
    repeat (4) send_pixel(8'hff, 8'hff, 8'hff);
    // write beyond the register list only restarts the frame
    wait_drained();
    write_reg(bfd_pkg::CFG_IDX_W'(7), $urandom_range(0, 8191));
    repeat (2) send_random_pixel();

    // random phases: mostly small frames, a few wide ones
    phase = 0;
    while (pixels_sent < RANDOM_PIX - 60) begin
      if ($urandom_range(0, 9) == 0) begin
        sw = $urandom_range(4000, 4096); sh = $urandom_range(1, 2);
        ow = $urandom_range(1, 8);       oh = 1;
      end else begin
        sw = $urandom_range(1, 10); sh = $urandom_range(1, 10);
        ow = $urandom_range(0, sw + 2); oh = $urandom_range(0, sh + 2);
      end
      wait_drained();
      order = '{bfd_pkg::REG_SRC_WIDTH, bfd_pkg::REG_SRC_HEIGHT,
                bfd_pkg::REG_OUT_WIDTH, bfd_pkg::REG_OUT_HEIGHT};
      order.shuffle();
      foreach (order[i]) begin
        case (order[i])
          bfd_pkg::REG_SRC_WIDTH:  write_reg(order[i], sw);
          bfd_pkg::REG_SRC_HEIGHT: write_reg(order[i], sh);
          bfd_pkg::REG_OUT_WIDTH:  write_reg(order[i], ow);
          default:                 write_reg(order[i], oh);
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(bfd_pkg::CFG_IDX_W'($urandom_range(4, 255)), 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      count = (sw > 100) ? $urandom_range(20, 60) : sw * sh * $urandom_range(1, 3) + 1;
      if (count > 120) count = 120;
      for (int unsigned i = 0; i < count; i++) begin
        if (phase == 2 && i == count / 2) hold_request = 1'b1;   // block backs up
        if (phase == 3 && i == count / 2) wait_drained();        // sender pause
        send_random_pixel();
      end
      phase++;
    end
    no_gaps = 1'b0;

    wait_drained();
    $display("run: %0d pixels, %0d averaged pixels, %0d frame ends, %0d register writes",
             pixels_sent, results_seen, frames_seen, reg_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

[box_filter_image_downscale.f]
+incdir+sv
sv/bfd_pkg.sv
sv/bfd_ram.sv
sv/bfd_ctrl.sv
sv/bfd_datapath.sv
sv/box_filter_image_downscale.sv
test/box_filter_image_downscale_checker.sv
test/tb_box_filter_image_downscale.sv
